@@ hw/rtl/rpd4n_pkg.sv @@
`default_nettype none

package rpd4n_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_VALUE_BITS = 16;

  // frame geometry
  localparam int ROW_LIMIT    = 1024;
  localparam int DIM_BITS     = 11;
  localparam int ROW_BITS     = 10;
  localparam int COL_OUT_BITS = 10;
  localparam logic [DIM_BITS-1:0] RESET_DIM = 11'd4;

  // peak count
  localparam int TOTAL_BITS = 20;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // result queue
  localparam int QDEPTH   = 16;
  localparam int MAX_PUSH = 4;

  // register port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/raster_peak_detector_4n_unit.sv @@
// Streaming 4-neighbour local maximum detector.
// Input: one signed sample per transfer on in_valid/in_stall, frame in raster
// order. Output: result items on out_valid/out_stall, one per transfer; a
// peak report (row, col, value) or, after the final sample of a frame, a
// summary with the peak count. out_last_of_run marks the final result caused
// by one sample. Frame size is set by two registers on the APB-style port
// (frame_width at 0x0, frame_height at 0x4); a write restarts the frame.
// Throughput: one sample per clock while in_stall is low, set by the single
// read and single write of the line memories per sample. A sample's first
// result is on the output after the edge following its transfer (memory
// read, then decide and queue).
// Results pass through a 16-entry queue; up to four results per sample drain
// at one per cycle while out_stall is low, so in_stall rises while the queue
// lacks room for the results of samples still in flight.
// out_stall holds the head result in place; samples keep being taken until
// the queue lacks room for the results of samples in flight.
// Reset: frame size 4 x 4, frame position and peak count at zero. The line
// memories are not cleared; every entry is written before its value is used.
`default_nettype none

module raster_peak_detector_4n_unit #(
  parameter int MAX_WIDTH  = rpd4n_pkg::DEF_MAX_WIDTH,
  parameter int VALUE_BITS = rpd4n_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // sample input
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [VALUE_BITS-1:0]           in_sample_value,
  // results
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_item_kind,
  output logic [rpd4n_pkg::ROW_BITS-1:0]              out_peak_row,
  output logic [rpd4n_pkg::COL_OUT_BITS-1:0]          out_peak_col,
  output logic signed [VALUE_BITS-1:0]                out_peak_value,
  output logic [rpd4n_pkg::TOTAL_BITS-1:0]            out_peak_total,
  output logic                                        out_last_of_run,
  // configuration
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [rpd4n_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  wire logic [rpd4n_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [rpd4n_pkg::APB_DATA_BITS-1:0]         prdata,
  output logic                                        pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RB  = rpd4n_pkg::ROW_BITS;
  localparam int DB  = rpd4n_pkg::DIM_BITS;
  localparam int TB  = rpd4n_pkg::TOTAL_BITS;
  localparam int QAW = $clog2(rpd4n_pkg::QDEPTH);

  typedef struct packed {
    logic                           kind;
    logic [RB-1:0]                  row;
    logic [rpd4n_pkg::COL_OUT_BITS-1:0] col;
    logic signed [VALUE_BITS-1:0]   value;
    logic [TB-1:0]                  total;
    logic                           last;
  } result_t;

  // ---------------------------------------------------------------- config
  logic [DB-1:0] width_r, height_r;
  logic          cfg_wr;
  rpd4n_pkg::reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = rpd4n_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rpd4n_pkg::RESET_DIM;
      height_r <= rpd4n_pkg::RESET_DIM;
    end else if (cfg_wr) begin
      case (reg_sel)
        rpd4n_pkg::REG_FRAME_WIDTH:  width_r  <= pwdata[DB-1:0];
        rpd4n_pkg::REG_FRAME_HEIGHT: height_r <= pwdata[DB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rpd4n_pkg::REG_FRAME_WIDTH:  prdata = rpd4n_pkg::APB_DATA_BITS'(width_r);
      rpd4n_pkg::REG_FRAME_HEIGHT: prdata = rpd4n_pkg::APB_DATA_BITS'(height_r);
      default:                     prdata = '0;
    endcase
  end

  // last column / row index, zero treated as one, oversize saturated
  logic [CW-1:0] last_col_idx;
  logic [RB-1:0] last_row_idx;

  always_comb begin
    if (width_r == '0)
      last_col_idx = '0;
    else if (32'(width_r) > MAX_WIDTH)
      last_col_idx = CW'(MAX_WIDTH - 1);
    else
      last_col_idx = CW'(width_r - DB'(1));

    if (height_r == '0)
      last_row_idx = '0;
    else if (32'(height_r) > rpd4n_pkg::ROW_LIMIT)
      last_row_idx = RB'(rpd4n_pkg::ROW_LIMIT - 1);
    else
      last_row_idx = RB'(height_r - DB'(1));
  end

  // ------------------------------------------------- stage 0: position, read
  logic          in_acc;
  logic [CW-1:0] c_r, c_nxt;
  logic [RB-1:0] r_r, r_nxt;
  logic          at_last_col, at_last_row;

  assign in_acc      = in_valid && !in_stall;
  assign at_last_col = (c_r == last_col_idx);
  assign at_last_row = (r_r == last_row_idx);

  always_comb begin
    c_nxt = c_r;
    r_nxt = r_r;
    if (in_acc) begin
      if (at_last_col) begin
        c_nxt = '0;
        r_nxt = at_last_row ? '0 : r_r + RB'(1);
      end else begin
        c_nxt = c_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      c_r <= '0;
      r_r <= '0;
    end else begin
      c_r <= c_nxt;
      r_r <= r_nxt;
    end
  end

  // stage 1 registers
  logic                         s1_valid_r;
  logic signed [VALUE_BITS-1:0] s1_val_r;
  logic [CW-1:0]                s1_col_r;
  logic [RB-1:0]                s1_row_r;
  logic                         s1_lc_r, s1_lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_val_r <= in_sample_value;
      s1_col_r <= c_r;
      s1_row_r <= r_r;
      s1_lc_r  <= at_last_col;
      s1_lr_r  <= at_last_row;
    end
  end

  // line memories: previous-row values and per-column candidate flags
  logic signed [VALUE_BITS-1:0] row_mem [MAX_WIDTH];
  logic                         flag_mem [MAX_WIDTH];
  logic signed [VALUE_BITS-1:0] up_r;
  logic                         flag_rd_r;
  logic                         left_ok;
  logic                         rs_hit, fl_hit;
  logic                         fl_wr;
  logic [CW-1:0]                fl_addr;

  // the entry being written back this edge may be the one read for the next sample
  assign fl_wr   = s1_valid_r && (s1_col_r != '0);
  assign fl_addr = s1_col_r - CW'(1);
  assign rs_hit  = s1_valid_r && (s1_col_r == c_r);
  assign fl_hit  = fl_wr && (fl_addr == c_r);

  always_ff @(posedge clk) begin
    if (s1_valid_r)
      row_mem[s1_col_r] <= s1_val_r;
    if (in_acc)
      up_r <= rs_hit ? s1_val_r : row_mem[c_r];
  end

  always_ff @(posedge clk) begin
    if (fl_wr)
      flag_mem[fl_addr] <= left_ok;
    if (in_acc)
      flag_rd_r <= fl_hit ? left_ok : flag_mem[c_r];
  end

  // --------------------------------------------------- stage 1: decide
  logic signed [VALUE_BITS-1:0] left_val_r;
  logic                         left_pend_r;
  logic                         flag_last_r;   // candidate flag of the last column
  logic [TB-1:0]                cnt_r;

  logic          up_flag, p_up, p_left, p_fin, is_sum, cand;
  logic [TB:0]   cnt_sum;
  logic [TB-1:0] cnt_sat;

  always_comb begin
    up_flag = s1_lc_r ? flag_last_r : flag_rd_r;
    p_up    = (s1_row_r != '0) && up_flag && (up_r > s1_val_r);
    left_ok = left_pend_r && (left_val_r > s1_val_r);
    p_left  = (s1_col_r != '0) && s1_lr_r && left_ok;
    cand    = ((s1_row_r == '0) || (s1_val_r > up_r)) &&
              ((s1_col_r == '0) || (s1_val_r > left_val_r));
    p_fin   = s1_lc_r && s1_lr_r && cand;
    is_sum  = s1_lc_r && s1_lr_r;
    cnt_sum = (TB+1)'(cnt_r) + (TB+1)'(p_up) + (TB+1)'(p_left) + (TB+1)'(p_fin);
    cnt_sat = (cnt_sum > (TB+1)'(rpd4n_pkg::TOTAL_MAX)) ? rpd4n_pkg::TOTAL_MAX
                                                         : cnt_sum[TB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      left_pend_r <= 1'b0;
      cnt_r       <= '0;
    end else if (s1_valid_r) begin
      left_pend_r <= s1_lc_r ? 1'b0 : cand;
      cnt_r       <= is_sum ? '0 : cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      left_val_r <= '0;
    end else if (s1_valid_r) begin
      left_val_r <= s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_lc_r)
      flag_last_r <= cand;
  end

  // gather this sample's results in order
  result_t    cands [rpd4n_pkg::MAX_PUSH];
  logic [3:0] cand_v;
  result_t    slot [rpd4n_pkg::MAX_PUSH];
  logic [2:0] push_n;

  always_comb begin
    cands[0] = '{kind: rpd4n_pkg::KIND_PEAK, row: s1_row_r - RB'(1),
                 col: rpd4n_pkg::COL_OUT_BITS'(s1_col_r), value: up_r,
                 total: '0, last: 1'b0};
    cands[1] = '{kind: rpd4n_pkg::KIND_PEAK, row: s1_row_r,
                 col: rpd4n_pkg::COL_OUT_BITS'(s1_col_r - CW'(1)), value: left_val_r,
                 total: '0, last: 1'b0};
    cands[2] = '{kind: rpd4n_pkg::KIND_PEAK, row: s1_row_r,
                 col: rpd4n_pkg::COL_OUT_BITS'(s1_col_r), value: s1_val_r,
                 total: '0, last: 1'b0};
    cands[3] = '{kind: rpd4n_pkg::KIND_SUMMARY, row: '0, col: '0, value: '0,
                 total: cnt_sat, last: 1'b0};
    cand_v   = {is_sum, p_fin, p_left, p_up} & {4{s1_valid_r}};

    push_n = '0;
    for (int i = 0; i < rpd4n_pkg::MAX_PUSH; i++)
      slot[i] = '0;
    for (int i = 0; i < rpd4n_pkg::MAX_PUSH; i++) begin
      if (cand_v[i]) begin
        slot[push_n[1:0]] = cands[i];
        push_n            = push_n + 3'd1;
      end
    end
    if (push_n != '0)
      slot[2'(push_n - 3'd1)].last = 1'b1;
  end

  // --------------------------------------------------- result queue
  result_t        q_mem [rpd4n_pkg::QDEPTH];
  logic [QAW-1:0] q_wr_r, q_rd_r;
  logic [QAW:0]   q_cnt_r, q_cnt_nxt;
  logic [QAW+1:0] occ;
  logic           pop;
  result_t        head;

  assign head      = q_mem[q_rd_r];
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign q_cnt_nxt = q_cnt_r + (QAW+1)'(push_n) - (QAW+1)'(pop);

  // room for the results of the sample in stage 1 and of one more
  assign occ      = (QAW+2)'(q_cnt_r) +
                    (s1_valid_r ? (QAW+2)'(rpd4n_pkg::MAX_PUSH) : '0);
  assign in_stall = occ > (QAW+2)'(rpd4n_pkg::QDEPTH - rpd4n_pkg::MAX_PUSH);

  always_ff @(posedge clk) begin
    for (int k = 0; k < rpd4n_pkg::MAX_PUSH; k++) begin
      if (3'(k) < push_n)
        q_mem[q_wr_r + QAW'(k)] <= slot[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + QAW'(push_n);
      q_rd_r  <= q_rd_r + QAW'(pop);
      q_cnt_r <= q_cnt_nxt;
    end
  end

  assign out_item_kind   = head.kind;
  assign out_peak_row    = head.row;
  assign out_peak_col    = head.col;
  assign out_peak_value  = head.value;
  assign out_peak_total  = head.total;
  assign out_last_of_run = head.last;

  // --------------------------------------------------- assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (QAW+1)'(rpd4n_pkg::QDEPTH))
    else $error("result queue overflow");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == rpd4n_pkg::KIND_SUMMARY) |-> out_last_of_run)
    else $error("summary not marked as last result");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_lc_r |-> (c_r == '0))
    else $error("column counter did not wrap after last column");

endmodule

`default_nettype wire
